FILE: sv/refcounted_inode_cache_table_top_assert.svh
// Assertion macros for the inode cache table.
// Included by files that carry concurrent checks; no dependencies.
`ifndef REFCOUNTED_INODE_CACHE_TABLE_TOP_ASSERT_SVH
`define REFCOUNTED_INODE_CACHE_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RICT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rict: same-cycle check failed");
`define RICT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rict: next-cycle check failed");
`else
`define RICT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RICT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/rict_pkg.sv
// Shared codes for the inode cache table: operation and status codes.
// No dependencies.
`timescale 1ns / 1ps

package rict_pkg;

   localparam logic [1:0] OP_GET  = 2'd0;
   localparam logic [1:0] OP_DUP  = 2'd1;
   localparam logic [1:0] OP_PUT  = 2'd2;
   localparam logic [1:0] OP_LOAD = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_NOREF    = 3'd2;
   localparam logic [2:0] ST_NOTYPE   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

endpackage

FILE: sv/rict_if.sv
// Request and response channel interfaces for the inode cache table.
// Plain valid/ready channels; no dependencies.
`timescale 1ns / 1ps

interface rict_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  device;
   logic [31:0] inode_number;
   logic [5:0]  slot;
   logic [3:0]  disk_type;
   logic [15:0] disk_links;

   modport source (output valid, op, device, inode_number, slot, disk_type, disk_links,
                   input ready);
   modport sink (input valid, op, device, inode_number, slot, disk_type, disk_links,
                 output ready);
endinterface

interface rict_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  slot_out;
   logic        was_cached;
   logic        acquire_device;
   logic        release_device;
   logic [7:0]  release_device_id;
   logic        delete_inode;
   logic [31:0] deleted_number;
   logic [2:0]  status;

   modport source (output valid, slot_out, was_cached, acquire_device, release_device,
                   release_device_id, delete_inode, deleted_number, status,
                   input ready);
   modport sink (input valid, slot_out, was_cached, acquire_device, release_device,
                 release_device_id, delete_inode, deleted_number, status,
                 output ready);
endinterface

FILE: sv/rict_entry_mem.sv
// Entry store of the inode cache table: one write port, one read port,
// registered read data. No dependencies.
`timescale 1ns / 1ps

module rict_entry_mem #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 69,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] entry_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/refcounted_inode_cache_table_top.sv
// Reference-counted inode cache table, top level: sequencer, entry update
// logic and response register. Uses rict_pkg, rict_if.sv, rict_entry_mem.
//
//   channel   dir   handshake      word
//   req_bus   in    valid/ready    op, device, inode_number, slot, disk_type, disk_links
//   rsp_bus   out   valid/ready    slot_out, flags, device id, deleted number, status
//
// A get reads the entry store one entry per cycle through its single read
// port; on a miss the scan covers every entry, a hit ends it early. Dup, put
// and load read only their one slot. One word is processed at a time.
// After reset a clearing pass over all TABLE_ENTRIES entries zeroes the store;
// req_bus.ready stays low until it ends. A result waiting on rsp_bus does
// not stop the next word from being accepted; the write-back waits for it.
`timescale 1ns / 1ps
`include "refcounted_inode_cache_table_top_assert.svh"

module refcounted_inode_cache_table_top #(
   parameter int TABLE_ENTRIES = 64,
   parameter int REF_BITS      = 8
) (
   input logic        clock,
   input logic        reset,
   rict_req_if.sink   req_bus,
   rict_rsp_if.source rsp_bus
);
   import rict_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [REF_BITS-1:0] REF_MAX  = '1;
   localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SLOT  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   typedef struct packed {
      logic [7:0]          dev;
      logic [31:0]         num;
      logic [REF_BITS-1:0] refs;
      logic                loaded;
      logic [3:0]          kind;
      logic [15:0]         links;
   } entry_type;

   localparam int WORD_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  device;
      logic [31:0] inode_number;
      logic [5:0]  slot;
      logic [3:0]  disk_type;
      logic [15:0] disk_links;
   } req_type;

   typedef struct packed {
      logic [5:0]  slot_out;
      logic        was_cached;
      logic        acquire_device;
      logic        release_device;
      logic [7:0]  release_device_id;
      logic        delete_inode;
      logic [31:0] deleted_number;
      logic [2:0]  status;
   } result_type;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issue_ff, issue_in;
   logic             rdv_ff, rdv_in;
   logic             hit_ff, hit_in;
   logic             free_ff, free_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] sel_idx_ff, sel_idx_in;
   entry_type        sel_word_ff, sel_word_in;
   logic             in_range_ff, in_range_in;
   req_type          req_ff, req_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic             fire;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_bits;
   entry_type        mem_rd_data;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   result_type       res;
   logic             upd_we;
   entry_type        upd_word;
   logic             scan_hit;
   logic             in_write_phase;
   logic             slot_accept;
   logic             rsp_delete;
   logic             rsp_release_ok;

   rict_entry_mem #(
      .DEPTH  (TABLE_ENTRIES),
      .WIDTH  (WORD_W),
      .ADDR_W (IDX_W)
   ) u_entry_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_bits)
   );

   assign mem_rd_data    = entry_type'(mem_rd_bits);
   assign req_bus.ready  = (state_ff == S_IDLE);
   assign req_accept     = req_bus.valid && req_bus.ready;
   assign fire           = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   assign mem_rd_addr    = (state_ff == S_SCAN) ? addr_ff : IDX_W'(req_bus.slot);
   assign scan_hit       = (mem_rd_data.refs != '0) && (mem_rd_data.dev == req_ff.device)
                           && (mem_rd_data.num == req_ff.inode_number);

   // Result and write-back word for the selected entry.
   always_comb begin
      res      = '0;
      upd_we   = 1'b0;
      upd_word = sel_word_ff;
      if (req_ff.op == OP_GET) begin
         if (hit_ff) begin
            res.slot_out   = 6'(sel_idx_ff);
            res.was_cached = 1'b1;
            if (sel_word_ff.refs == REF_MAX) begin
               res.status = ST_OVERFLOW;
            end else begin
               upd_word.refs = REF_BITS'(sel_word_ff.refs + REF_ONE);
               upd_we        = 1'b1;
            end
         end else if (free_ff) begin
            res.slot_out          = 6'(sel_idx_ff);
            res.acquire_device    = 1'b1;
            res.release_device_id = req_ff.device;
            upd_word.dev          = req_ff.device;
            upd_word.num          = req_ff.inode_number;
            upd_word.refs         = REF_ONE;
            upd_word.loaded       = 1'b0;
            upd_we                = 1'b1;
         end else begin
            res.status = ST_FULL;
         end
      end else begin
         res.slot_out = req_ff.slot;
         if (!(in_range_ff && sel_word_ff.refs != '0)) begin
            res.status = ST_NOREF;
         end else if (req_ff.op == OP_DUP) begin
            if (sel_word_ff.refs == REF_MAX) begin
               res.status = ST_OVERFLOW;
            end else begin
               upd_word.refs = REF_BITS'(sel_word_ff.refs + REF_ONE);
               upd_we        = 1'b1;
            end
         end else if (req_ff.op == OP_LOAD) begin
            // an entry that is already loaded ignores the disk fields
            if (!sel_word_ff.loaded) begin
               if (req_ff.disk_type == '0) begin
                  res.status = ST_NOTYPE;
               end else begin
                  upd_word.kind   = req_ff.disk_type;
                  upd_word.links  = req_ff.disk_links;
                  upd_word.loaded = 1'b1;
                  upd_we          = 1'b1;
               end
            end
         end else begin
            if (sel_word_ff.loaded && sel_word_ff.links == '0 && sel_word_ff.refs == REF_ONE)
            begin
               res.delete_inode   = 1'b1;
               res.deleted_number = sel_word_ff.num;
               upd_word.kind      = '0;
               upd_word.loaded    = 1'b0;
            end
            upd_word.refs = REF_BITS'(sel_word_ff.refs - REF_ONE);
            upd_we        = 1'b1;
            if (sel_word_ff.refs == REF_ONE) begin
               res.release_device    = 1'b1;
               res.release_device_id = sel_word_ff.dev;
            end
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      issue_in     = issue_ff;
      rdv_in       = 1'b0;
      hit_in       = hit_ff;
      free_in      = free_ff;
      rd_idx_in    = rd_idx_ff;
      sel_idx_in   = sel_idx_ff;
      sel_word_in  = sel_word_ff;
      in_range_in  = in_range_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wr_addr  = sel_idx_ff;
      mem_wr_data  = upd_word;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_wr_addr = addr_ff;
            mem_wr_data = '0;
            if (addr_ff == LAST_IDX) begin
               state_in = S_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = IDX_W'(addr_ff + 1'b1);
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               req_in.op           = req_bus.op;
               req_in.device       = req_bus.device;
               req_in.inode_number = req_bus.inode_number;
               req_in.slot         = req_bus.slot;
               req_in.disk_type    = req_bus.disk_type;
               req_in.disk_links   = req_bus.disk_links;
               if (req_bus.op == OP_GET) begin
                  state_in = S_SCAN;
                  addr_in  = '0;
                  issue_in = 1'b1;
                  hit_in   = 1'b0;
                  free_in  = 1'b0;
               end else begin
                  // the slot read goes out this cycle
                  state_in    = S_SLOT;
                  sel_idx_in  = IDX_W'(req_bus.slot);
                  in_range_in = (32'(req_bus.slot) < 32'(TABLE_ENTRIES));
               end
            end
         end
         S_SCAN: begin
            rdv_in    = issue_ff;
            rd_idx_in = addr_ff;
            if (issue_ff) begin
               if (addr_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = IDX_W'(addr_ff + 1'b1);
               end
            end
            if (rdv_ff) begin
               if (scan_hit) begin
                  hit_in      = 1'b1;
                  sel_idx_in  = rd_idx_ff;
                  sel_word_in = mem_rd_data;
                  state_in    = S_DONE;
               end else begin
                  // remember the lowest free entry; a later hit overrides it
                  if (mem_rd_data.refs == '0 && !free_ff) begin
                     free_in     = 1'b1;
                     sel_idx_in  = rd_idx_ff;
                     sel_word_in = mem_rd_data;
                  end
                  if (rd_idx_ff == LAST_IDX) begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_SLOT: begin
            sel_word_in = mem_rd_data;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (fire) begin
               mem_we   = upd_we;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            addr_in  = '0;
         end
      endcase

      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         issue_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         issue_ff     <= issue_in;
         rdv_ff       <= rdv_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      sel_idx_ff  <= sel_idx_in;
      sel_word_ff <= sel_word_in;
      in_range_ff <= in_range_in;
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.slot_out          = rsp_data_ff.slot_out;
   assign rsp_bus.was_cached        = rsp_data_ff.was_cached;
   assign rsp_bus.acquire_device    = rsp_data_ff.acquire_device;
   assign rsp_bus.release_device    = rsp_data_ff.release_device;
   assign rsp_bus.release_device_id = rsp_data_ff.release_device_id;
   assign rsp_bus.delete_inode      = rsp_data_ff.delete_inode;
   assign rsp_bus.deleted_number    = rsp_data_ff.deleted_number;
   assign rsp_bus.status            = rsp_data_ff.status;

   assign in_write_phase = (state_ff == S_CLEAR) || (state_ff == S_DONE);
   assign slot_accept    = req_accept && (req_bus.op != OP_GET);
   assign rsp_delete     = rsp_valid_ff && rsp_data_ff.delete_inode;
   assign rsp_release_ok = rsp_data_ff.release_device && (rsp_data_ff.status == ST_OK);

   `RICT_ASSERT_IMPLIES(a_scan_addr_bound, clock, reset, state_ff == S_SCAN, addr_ff <= LAST_IDX)
   `RICT_ASSERT_IMPLIES(a_write_phase, clock, reset, mem_we, in_write_phase)
   `RICT_ASSERT_IMPLIES(a_delete_releases, clock, reset, rsp_delete, rsp_release_ok)
   `RICT_ASSERT_NEXT(a_slot_op_reads, clock, reset, slot_accept, state_ff == S_SLOT)

endmodule

FILE: verif/refcounted_inode_cache_table_top_tb.sv
// Testbench for refcounted_inode_cache_table_top: directed and random traffic
// on req_bus, each rsp_bus word checked against an in-bench inode table model.
// Depends on rict_pkg, rict_if.sv and the RTL under sv/.
`timescale 1ns / 1ps

module refcounted_inode_cache_table_top_tb;
   import rict_pkg::*;

   localparam int         ENTRIES      = 64;
   localparam logic [7:0] REF_MAX      = 8'hFF;
   localparam int         LIMIT_CYCLES = 4000;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  device;
      logic [31:0] inode_number;
      logic [5:0]  slot;
      logic [3:0]  disk_type;
      logic [15:0] disk_links;
   } inode_req_type;

   typedef struct packed {
      logic [5:0]  slot_out;
      logic        was_cached;
      logic        acquire_device;
      logic        release_device;
      logic [7:0]  release_device_id;
      logic        delete_inode;
      logic [31:0] deleted_number;
      logic [2:0]  status;
   } inode_rsp_type;

   logic clock = 1'b0;
   logic reset;

   rict_req_if req_bus();
   rict_rsp_if rsp_bus();

   refcounted_inode_cache_table_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model of the entry table
   logic [7:0]  cache_device [ENTRIES];
   logic [31:0] cache_number [ENTRIES];
   logic [7:0]  cache_refs   [ENTRIES];
   logic        cache_loaded [ENTRIES];
   logic [15:0] cache_links  [ENTRIES];
   logic [3:0]  cache_kind   [ENTRIES];

   inode_rsp_type pending_results [$];
   inode_rsp_type last_result;
   int         errors = 0;
   int         burst_left = 0;
   int         idle_cycles = 0;
   int         stall_left = 0;
   int         stall_mode = 0;

   function automatic inode_rsp_type predict_inode_result(inode_req_type w);
      inode_rsp_type r;
      int         i;
      int         hit;
      int         free_idx;
      r = '0;
      hit = -1;
      free_idx = -1;
      if (w.op == OP_GET) begin
         for (i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && cache_refs[i] != 0 && cache_device[i] == w.device &&
                cache_number[i] == w.inode_number)
               hit = i;
            if (hit < 0 && free_idx < 0 && cache_refs[i] == 0)
               free_idx = i;
         end
         if (hit >= 0) begin
            r.slot_out = hit[5:0];
            r.was_cached = 1'b1;
            if (cache_refs[hit] == REF_MAX)
               r.status = ST_OVERFLOW;
            else
               cache_refs[hit] = cache_refs[hit] + 8'd1;
         end else if (free_idx >= 0) begin
            r.slot_out = free_idx[5:0];
            cache_device[free_idx] = w.device;
            cache_number[free_idx] = w.inode_number;
            cache_refs[free_idx] = 8'd1;
            cache_loaded[free_idx] = 1'b0;
            r.acquire_device = 1'b1;
            r.release_device_id = w.device;
         end else begin
            r.status = ST_FULL;
         end
      end else begin
         r.slot_out = w.slot;
         if (cache_refs[w.slot] == 0) begin
            r.status = ST_NOREF;
         end else if (w.op == OP_DUP) begin
            if (cache_refs[w.slot] == REF_MAX)
               r.status = ST_OVERFLOW;
            else
               cache_refs[w.slot] = cache_refs[w.slot] + 8'd1;
         end else if (w.op == OP_LOAD) begin
            // an already loaded entry ignores the disk fields
            if (!cache_loaded[w.slot]) begin
               if (w.disk_type == 0) begin
                  r.status = ST_NOTYPE;
               end else begin
                  cache_kind[w.slot] = w.disk_type;
                  cache_links[w.slot] = w.disk_links;
                  cache_loaded[w.slot] = 1'b1;
               end
            end
         end else begin
            if (cache_loaded[w.slot] && cache_links[w.slot] == 0 &&
                cache_refs[w.slot] == 8'd1) begin
               r.delete_inode = 1'b1;
               r.deleted_number = cache_number[w.slot];
               cache_kind[w.slot] = 4'd0;
               cache_loaded[w.slot] = 1'b0;
            end
            cache_refs[w.slot] = cache_refs[w.slot] - 8'd1;
            if (cache_refs[w.slot] == 0) begin
               r.release_device = 1'b1;
               r.release_device_id = cache_device[w.slot];
            end
         end
      end
      return r;
   endfunction

   function automatic inode_req_type rand_word(logic [1:0] op);
      inode_req_type w;
      w.op = op;
      w.device = 8'($urandom_range(0, 255));
      w.inode_number = $urandom;
      w.slot = 6'($urandom_range(0, 63));
      w.disk_type = 4'($urandom_range(0, 15));
      w.disk_links = 16'($urandom_range(0, 65535));
      return w;
   endfunction

   function automatic int free_entries();
      int i;
      int n;
      n = 0;
      for (i = 0; i < ENTRIES; i++)
         if (cache_refs[i] == 0)
            n++;
      return n;
   endfunction

   function automatic int pick_held_slot();
      int i;
      int held [$];
      for (i = 0; i < ENTRIES; i++)
         if (cache_refs[i] != 0)
            held.push_back(i);
      if (held.size() == 0)
         return -1;
      return held[$urandom_range(0, held.size() - 1)];
   endfunction

   // Called right after a rising edge; returns right after the accepting edge.
   task automatic send_word(inode_req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.op           <= w.op;
      req_bus.device       <= w.device;
      req_bus.inode_number <= w.inode_number;
      req_bus.slot         <= w.slot;
      req_bus.disk_type    <= w.disk_type;
      req_bus.disk_links   <= w.disk_links;
      do @(posedge clock); while (!req_bus.ready);
      last_result = predict_inode_result(w);
      pending_results.push_back(last_result);
   endtask

   task automatic send_get(logic [7:0] dev, logic [31:0] num);
      inode_req_type w;
      w = rand_word(OP_GET);
      w.device = dev;
      w.inode_number = num;
      send_word(w);
   endtask

   task automatic send_slot_op(logic [1:0] op, logic [5:0] slot, logic [3:0] dtype,
                               logic [15:0] dlinks);
      inode_req_type w;
      w = rand_word(op);
      w.slot = slot;
      w.disk_type = dtype;
      w.disk_links = dlinks;
      send_word(w);
   endtask

   task automatic test_get_and_hit();
      send_get(8'h00, 32'h0000_0000);
      send_get(8'hFF, 32'hFFFF_FFFF);
      send_get(8'h00, 32'h0000_0000);
      // number of one entry, device of another: must miss
      send_get(8'h00, 32'hFFFF_FFFF);
   endtask

   task automatic test_dup_and_load();
      send_slot_op(OP_DUP, 6'd1, 4'd0, 16'd0);
      send_slot_op(OP_LOAD, 6'd1, 4'd0, 16'd5);
      send_slot_op(OP_LOAD, 6'd1, 4'hF, 16'hFFFF);
      send_slot_op(OP_LOAD, 6'd1, 4'd1, 16'd0);
   endtask

   task automatic test_release_and_reclaim();
      send_slot_op(OP_PUT, 6'd1, 4'd0, 16'd0);
      send_slot_op(OP_PUT, 6'd1, 4'd0, 16'd0);
      // reclaim clears the loaded flag, so a typeless load fails again
      send_get(8'hFF, 32'hFFFF_FFFF);
      send_slot_op(OP_LOAD, 6'd1, 4'd0, 16'd0);
   endtask

   task automatic test_delete_on_last_put();
      send_slot_op(OP_LOAD, 6'd2, 4'd8, 16'd0);
      send_slot_op(OP_DUP, 6'd2, 4'd0, 16'd0);
      send_slot_op(OP_PUT, 6'd2, 4'd0, 16'd0);
      send_slot_op(OP_PUT, 6'd2, 4'd0, 16'd0);
   endtask

   task automatic test_missing_reference();
      send_slot_op(OP_DUP, 6'd63, 4'hF, 16'hFFFF);
      send_slot_op(OP_PUT, 6'd63, 4'hF, 16'hFFFF);
      send_slot_op(OP_LOAD, 6'd63, 4'hF, 16'hFFFF);
      send_slot_op(OP_PUT, 6'd2, 4'd0, 16'd0);
   endtask

   task automatic test_count_overflow();
      inode_req_type key;
      logic [5:0] s;
      key = rand_word(OP_GET);
      send_word(key);
      s = last_result.slot_out;
      if (cache_refs[s] != 0) begin
         // count up by a mix of get hits and dups
         while (cache_refs[s] != REF_MAX) begin
            if ($urandom_range(0, 1))
               send_slot_op(OP_DUP, s, 4'($urandom_range(0, 15)), 16'($urandom));
            else
               send_get(key.device, key.inode_number);
         end
         send_slot_op(OP_DUP, s, 4'd0, 16'd0);
         send_get(key.device, key.inode_number);
      end
   endtask

   task automatic test_table_full();
      int claimed [$];
      int s;
      while (free_entries() > 0) begin
         send_word(rand_word(OP_GET));
         if (last_result.acquire_device)
            claimed.push_back(int'(last_result.slot_out));
      end
      send_word(rand_word(OP_GET));
      s = pick_held_slot();
      send_get(cache_device[s], cache_number[s]);
      foreach (claimed[i]) begin
         if ($urandom_range(0, 1))
            send_slot_op(OP_LOAD, 6'(claimed[i]), 4'($urandom_range(0, 15)),
                         ($urandom_range(0, 1)) ? 16'd0 : 16'($urandom));
         send_slot_op(OP_PUT, 6'(claimed[i]), 4'd0, 16'd0);
      end
   endtask

   task automatic test_random_traffic(int count);
      inode_req_type w;
      int         pick;
      int         s;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         s = pick_held_slot();
         if (s < 0 || pick < 30) begin
            w = rand_word(OP_GET);
            if (s >= 0 && $urandom_range(0, 1)) begin
               w.device = cache_device[s];
               w.inode_number = cache_number[s];
            end else if ($urandom_range(0, 3) == 0) begin
               w.device = 8'($urandom_range(0, 3));
            end
         end else if (pick < 45) begin
            w = rand_word(OP_DUP);
            w.slot = 6'(s);
         end else if (pick < 75) begin
            w = rand_word(OP_PUT);
            w.slot = 6'(s);
         end else if (pick < 92) begin
            w = rand_word(OP_LOAD);
            w.slot = 6'(s);
            if ($urandom_range(0, 1))
               w.disk_links = 16'd0;
         end else begin
            w = rand_word(2'($urandom_range(0, 3)));
         end
         send_word(w);
      end
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      inode_rsp_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing pending, slot_out %0d", rsp_bus.slot_out);
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            check_field("slot_out", 32'(exp_r.slot_out), 32'(rsp_bus.slot_out));
            check_field("was_cached", 32'(exp_r.was_cached), 32'(rsp_bus.was_cached));
            check_field("acquire_device", 32'(exp_r.acquire_device),
                        32'(rsp_bus.acquire_device));
            check_field("release_device", 32'(exp_r.release_device),
                        32'(rsp_bus.release_device));
            check_field("release_device_id", 32'(exp_r.release_device_id),
                        32'(rsp_bus.release_device_id));
            check_field("delete_inode", 32'(exp_r.delete_inode),
                        32'(rsp_bus.delete_inode));
            check_field("deleted_number", exp_r.deleted_number, rsp_bus.deleted_number);
            check_field("status", 32'(exp_r.status), 32'(rsp_bus.status));
         end
      end
   end

   // receiver: segments of always-ready, coin-flip, mostly-stalled and blocked runs
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(4, 40);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_bus.ready <= ~stall_left[3];
      endcase
   end

   // no word accepted on either side for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT_CYCLES) begin
         $display("refcounted_inode_cache_table_top: mismatch");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         cache_device[i] = '0;
         cache_number[i] = '0;
         cache_refs[i]   = '0;
         cache_loaded[i] = 1'b0;
         cache_links[i]  = '0;
         cache_kind[i]   = '0;
      end
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_GET;
      req_bus.device       = '0;
      req_bus.inode_number = '0;
      req_bus.slot         = '0;
      req_bus.disk_type    = '0;
      req_bus.disk_links   = '0;
      rsp_bus.ready        = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_get_and_hit();
      test_dup_and_load();
      test_release_and_reclaim();
      test_delete_on_last_put();
      test_missing_reference();
      test_count_overflow();
      test_table_full();
      test_random_traffic(70);

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
      if (errors == 0)
         $display("refcounted_inode_cache_table_top: match");
      else
         $display("refcounted_inode_cache_table_top: mismatch");
      $finish;
   end

endmodule
